[rtl/bloom_filter_xorshift_macros.svh]
// assertion macros for the bloom filter block
`ifndef BLOOM_FILTER_XORSHIFT_MACROS_SVH
`define BLOOM_FILTER_XORSHIFT_MACROS_SVH
`ifndef ASSERT_OFF
`define BFX_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFX_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFX_ASSERT(label, clk, rst_n, prop, msg)
`define BFX_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[rtl/bfx_pkg.sv]
package bfx_pkg;
    localparam int KEY_W   = 64;
    localparam int COUNT_W = 32;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 32;
    localparam int HK_W    = 5;
    localparam int SIZE_W  = 17;
    localparam int BW_W    = 16;

    localparam logic [IDX_W-1:0] REG_BLOCKED_MODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_NUM_HASHES   = 2'd1;
    localparam logic [IDX_W-1:0] REG_FILTER_SIZE  = 2'd2;
    localparam logic [IDX_W-1:0] REG_BLOCK_WIDTH  = 2'd3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // one xorshift step, shift is 0 when amount reaches 64
    function automatic logic [KEY_W-1:0] xs_step(input logic [KEY_W-1:0] v,
                                                 input logic [11:0] amt);
        logic [KEY_W-1:0] r;
        r = (amt >= 12'd64) ? '0 : (v << amt[5:0]);
        return v ^ r;
    endfunction
endpackage

[rtl/bfx_if.sv]
interface bfx_in_if;
    import bfx_pkg::*;
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [KEY_W-1:0] key;
    modport source (output valid, cmd, key, input ready);
    modport sink   (input valid, cmd, key, output ready);
endinterface

interface bfx_out_if;
    import bfx_pkg::*;
    logic               valid;
    logic               ready;
    logic               found;
    logic [COUNT_W-1:0] count;
    logic               error;
    modport source (output valid, found, count, error, input ready);
    modport sink   (input valid, found, count, error, output ready);
endinterface

interface bfx_cfg_if;
    import bfx_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/bfx_ram.sv]
module bfx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/bfx_mod.sv]
// sequential remainder: one quotient bit per cycle, numerator is 64 bits
module bfx_mod #(
    parameter int DW = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [DW-1:0] rem
);
    logic [DW:0]   rem_reg;
    logic [63:0]   num_reg;
    logic [6:0]    cnt_reg;
    logic          busy_reg;
    logic [DW:0]   trial;
    logic [DW+1:0] shifted;

    assign shifted = {rem_reg, num_reg[63]};
    assign trial   = shifted[DW:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
                rem_reg  <= '0;
                num_reg  <= num;
            end
            else if (busy_reg)
            begin
                num_reg <= num_reg << 1;
                if (shifted >= {1'b0, 1'b0, den})
                begin
                    rem_reg <= trial - {1'b0, den};
                end
                else
                begin
                    rem_reg <= trial;
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign rem = rem_reg[DW-1:0];
endmodule

[rtl/bloom_filter_xorshift.sv]
// Bloom filter over 64-bit keys with a seeded xorshift hash family.
// Channels: in_ch takes a transaction of cmd (0 insert, 1 query) and key;
// out_ch gives one transaction per input with found, count and error;
// cfg_ch writes blocked_mode, num_hashes, filter_size, block_width by index.
// Items are handled one at a time. Each hash takes three xorshift steps,
// a bit-serial remainder and a read-modify-write of one bit in the filter
// RAM; a blocked key spends its first hash on the base. The next key is
// accepted only once the last result is registered; a query stops at its
// first clear bit, and in blocked mode an unusable block width goes straight
// to the result with error set.
// After reset the filter RAM is swept clear, one word per cycle, while in_ch
// is held not ready; cfg writes are taken.
// The result sits in an output register, so the next key is accepted while it
// waits; a stalled receiver holds that next key at its end, then in_ch goes low.
module bloom_filter_xorshift
    import bfx_pkg::*;
#(
    parameter int FILTER_BITS = 65536,
    parameter int MAX_HASHES  = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    bfx_in_if.sink    in_ch,
    bfx_out_if.source out_ch,
    bfx_cfg_if.sink   cfg_ch
);
    `include "bloom_filter_xorshift_macros.svh"

    localparam int WB    = 32;
    localparam int WORDS = (FILTER_BITS + WB - 1) / WB;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = $clog2(FILTER_BITS + 1) + 1;
    localparam int MW    = (PW > SIZE_W) ? PW : SIZE_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_BASE_HASH, S_BASE_WAIT, S_HASH, S_MOD_WAIT,
        S_READ, S_RMW, S_DONE
    } state_t;

    state_t state_reg;
    logic              blocked_reg;
    logic [HK_W-1:0]   hashes_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [BW_W-1:0]   bw_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic              cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [6:0]        seed_reg;
    logic [6:0]        klim_reg;
    logic [MW-1:0]     m_reg;
    logic [MW-1:0]     base_reg;
    logic [MW-1:0]     pos_reg;
    logic              changed_reg;
    logic              found_reg;
    logic              error_reg;
    logic              valid_reg;
    logic              out_found_reg;
    logic              out_error_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [AW-1:0]     clr_reg;
    logic [KEY_W-1:0]  h1_reg, h2_reg, hash_reg;
    logic [1:0]        hstep_reg;

    logic          mod_start;
    logic [MW-1:0] mod_den;
    logic          mod_done;
    logic [MW-1:0] mod_rem;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [WB-1:0] ram_wdata, ram_rdata;
    logic [4:0]    bit_sel;
    logic          bit_val;

    logic [HK_W-1:0] k_eff;
    logic [MW-1:0]   m_eff;
    logic [11:0]     s12;

    always_comb
    begin
        k_eff = hashes_reg;
        if (hashes_reg == '0)
        begin
            k_eff = HK_W'(1);
        end
        if (32'(hashes_reg) > MAX_HASHES)
        begin
            k_eff = HK_W'(MAX_HASHES);
        end
        m_eff = MW'(size_reg);
        if (size_reg == '0)
        begin
            m_eff = MW'(1);
        end
        if (32'(size_reg) > FILTER_BITS)
        begin
            m_eff = MW'(FILTER_BITS);
        end
    end

    // blocked insert counts once per key that changed a bit
    always_comb
    begin
        count_next = count_reg;
        if (blocked_reg && cmd_reg == CMD_INSERT && !error_reg &&
            changed_reg && count_reg != COUNT_MAX)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    assign s12       = {5'd0, seed_reg};
    assign bit_sel   = pos_reg[4:0];
    assign bit_val   = ram_rdata[bit_sel];
    assign ram_raddr = AW'(pos_reg >> 5);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg : ram_raddr;
    assign ram_we    = (state_reg == S_CLEAR) ||
                       (state_reg == S_RMW && cmd_reg == CMD_INSERT && !bit_val);
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : (ram_rdata | (WB'(1) << bit_sel));

    bfx_ram #(.WIDTH(WB), .DEPTH(WORDS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfx_mod #(.DW(MW)) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .num   (hash_reg),
        .den   (mod_den),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    // base uses m-w; offsets and plain positions use w or m
    assign mod_den = (state_reg == S_BASE_WAIT) ? (m_reg - MW'(bw_reg)) :
                     (blocked_reg ? MW'(bw_reg) : m_reg);

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = valid_reg;
    assign out_ch.found = out_found_reg;
    assign out_ch.count = out_count_reg;
    assign out_ch.error = out_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocked_reg <= 1'b0;
            hashes_reg  <= HK_W'(4);
            size_reg    <= SIZE_W'(65536);
            bw_reg      <= BW_W'(64);
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_BLOCKED_MODE: blocked_reg <= cfg_ch.data[0];
                REG_NUM_HASHES:   hashes_reg  <= cfg_ch.data[HK_W-1:0];
                REG_FILTER_SIZE:  size_reg    <= cfg_ch.data[SIZE_W-1:0];
                REG_BLOCK_WIDTH:  bw_reg      <= cfg_ch.data[BW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            valid_reg     <= 1'b0;
            out_found_reg <= 1'b0;
            out_error_reg <= 1'b0;
            out_count_reg <= '0;
            mod_start     <= 1'b0;
            hstep_reg     <= '0;
        end
        else
        begin
            mod_start <= 1'b0;
            if (out_ch.valid && out_ch.ready && state_reg != S_DONE)
            begin
                valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == WORDS - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        cmd_reg     <= in_ch.cmd;
                        key_reg     <= in_ch.key;
                        m_reg       <= m_eff;
                        changed_reg <= 1'b0;
                        found_reg   <= (in_ch.cmd == CMD_QUERY);
                        error_reg   <= 1'b0;
                        hstep_reg   <= '0;
                        h1_reg      <= in_ch.key;
                        if (blocked_reg)
                        begin
                            klim_reg <= 7'(k_eff);
                            if (bw_reg == '0 || MW'(bw_reg) >= m_eff)
                            begin
                                error_reg <= 1'b1;
                                found_reg <= 1'b0;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                seed_reg  <= 7'd1;
                                state_reg <= S_BASE_HASH;
                            end
                        end
                        else
                        begin
                            klim_reg  <= 7'(k_eff) - 7'd1;
                            seed_reg  <= 7'd0;
                            state_reg <= S_HASH;
                        end
                    end
                end
                S_BASE_HASH, S_HASH:
                begin
                    // one xorshift step per cycle
                    hstep_reg <= hstep_reg + 2'd1;
                    case (hstep_reg)
                        2'd0: h1_reg <= xs_step(key_reg, 12'(s12 * 12'd27));
                        2'd1: h2_reg <= xs_step(h1_reg, 12'(s12 * 12'd4));
                        default:
                        begin
                            hash_reg  <= xs_step(h2_reg, 12'(s12 * 12'd49));
                            hstep_reg <= '0;
                            mod_start <= 1'b1;
                            state_reg <= (state_reg == S_BASE_HASH) ? S_BASE_WAIT
                                                                    : S_MOD_WAIT;
                        end
                    endcase
                end
                S_BASE_WAIT:
                begin
                    if (mod_done)
                    begin
                        base_reg  <= mod_rem;
                        pos_reg   <= mod_rem;
                        state_reg <= S_READ;
                    end
                end
                S_MOD_WAIT:
                begin
                    if (mod_done)
                    begin
                        pos_reg   <= blocked_reg ? (base_reg + mod_rem) : mod_rem;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_RMW;
                end
                S_RMW:
                begin
                    if (cmd_reg == CMD_QUERY && !bit_val)
                    begin
                        found_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (cmd_reg == CMD_INSERT && !bit_val)
                        begin
                            changed_reg <= 1'b1;
                            if (!blocked_reg && count_reg != COUNT_MAX)
                            begin
                                count_reg <= count_reg + COUNT_W'(1);
                            end
                        end
                        if (seed_reg == klim_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            seed_reg  <= seed_reg + 7'd1;
                            state_reg <= S_HASH;
                        end
                    end
                end
                S_DONE:
                begin
                    // wait here while the previous result is still held
                    if (!valid_reg || out_ch.ready)
                    begin
                        count_reg     <= count_next;
                        out_count_reg <= count_next;
                        out_found_reg <= found_reg;
                        out_error_reg <= error_reg;
                        valid_reg     <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `BFX_ASSERT(a_out_hold, clk, rst_n,
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.found) &&
            $stable(out_ch.count) && $stable(out_ch.error)),
        "result changed while stalled")
    `BFX_ASSERT(a_error_no_found, clk, rst_n,
        out_ch.valid |-> !(out_ch.error && out_ch.found),
        "error and found both set")
    `BFX_ASSERT(a_count_mono, clk, rst_n,
        (state_reg != S_CLEAR) |=> (count_reg >= $past(count_reg)),
        "insert counter went down")
    `BFX_ASSERT_RST(a_clear_not_ready, clk,
        (state_reg == S_CLEAR) |-> !in_ch.ready,
        "input ready during clearing pass")
endmodule
